// ----- hw/rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with indexed read.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // field widths of the item ports
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned STAT_W = 2;

  // parameter defaults
  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned WIDTH_DEF = 32;

  // capacity after reset
  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_REM_HEAD = 3'd2,
    CMD_REM_TAIL = 3'd3,
    CMD_RD_HEAD  = 3'd4,
    CMD_RD_TAIL  = 3'd5,
    CMD_RD_INDEX = 3'd6,
    CMD_SIZE     = 3'd7
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // result of one command, minus the read word that the memory returns later
  typedef struct packed {
    logic [CNT_W-1:0] count;
    status_e          status;
    logic             rd;
  } res_t;

endpackage

// ----- hw/rtl/bdq_ram.sv -----
// ----------------------------------------------------------------------------
// bdq_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = bdq_pkg::WIDTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdq_ctrl
// Head pointer, entry count and capacity; decodes each command into at most one
// memory access and the result status.
// ----------------------------------------------------------------------------
module bdq_ctrl #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = bdq_pkg::WIDTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bdq_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                       acc_i,
  input  logic [bdq_pkg::CMD_W-1:0]  command_i,
  input  logic [bdq_pkg::DATA_W-1:0] entry_data_i,
  input  logic [bdq_pkg::IDX_W-1:0]  index_i,
  output logic                       we_o,
  output logic [AW-1:0]              waddr_o,
  output logic [WIDTH-1:0]           wdata_o,
  output logic                       re_o,
  output logic [AW-1:0]              raddr_o,
  output bdq_pkg::res_t              res_o
);

  // slot arithmetic width: holds head plus any offset, and DEPTH itself
  localparam int unsigned SW = ((AW > bdq_pkg::CNT_W) ? AW : bdq_pkg::CNT_W) + 1;

  logic [AW-1:0]             head_q, head_d;
  logic [bdq_pkg::CNT_W-1:0] count_q, count_d;
  logic [bdq_pkg::CNT_W-1:0] cap_q;
  logic [SW-1:0]             cap_eff;
  logic [SW-1:0]             off;
  logic [SW-1:0]             sum;
  logic [AW-1:0]             slot;
  logic [AW-1:0]             head_dec;
  logic [63:0]               data_ext;
  bdq_pkg::cmd_e             cmd;
  bdq_pkg::status_e          status;
  logic                      empty;
  logic                      full;
  logic                      rd;

  assign cmd   = bdq_pkg::cmd_e'(command_i);
  assign empty = (count_q == '0);

  // capacity saturates at the store depth
  assign cap_eff = (SW'(cap_q) > SW'(DEPTH)) ? SW'(DEPTH) : SW'(cap_q);
  assign full    = (SW'(count_q) >= cap_eff);

  // offset from the head for the one ring slot this command touches
  always_comb begin
    unique case (cmd)
      bdq_pkg::CMD_INS_TAIL: off = SW'(count_q);
      bdq_pkg::CMD_REM_HEAD: off = SW'(1);
      bdq_pkg::CMD_RD_TAIL:  off = SW'(count_q) - SW'(1);
      bdq_pkg::CMD_RD_INDEX: off = SW'(index_i);
      default:               off = '0;
    endcase
  end

  // ring wrap: offset is below DEPTH whenever the slot is used, so one subtract suffices
  always_comb begin
    sum = SW'(head_q) + off;
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
  end
  assign slot     = sum[AW-1:0];
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

  // command decode
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    status  = bdq_pkg::ST_OK;
    rd      = 1'b0;
    we_o    = 1'b0;
    waddr_o = slot;
    unique case (cmd)
      bdq_pkg::CMD_INS_HEAD, bdq_pkg::CMD_INS_TAIL: begin
        if (full) begin
          status = bdq_pkg::ST_FULL;
        end else begin
          we_o    = acc_i;
          count_d = count_q + 1'b1;
          if (cmd == bdq_pkg::CMD_INS_HEAD) begin
            head_d  = head_dec;
            waddr_o = head_dec;
          end
        end
      end
      bdq_pkg::CMD_REM_HEAD, bdq_pkg::CMD_REM_TAIL: begin
        if (empty) begin
          status = bdq_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
          if (cmd == bdq_pkg::CMD_REM_HEAD) begin
            head_d = slot;
          end
        end
      end
      bdq_pkg::CMD_RD_HEAD, bdq_pkg::CMD_RD_TAIL, bdq_pkg::CMD_RD_INDEX: begin
        if (empty) begin
          status = bdq_pkg::ST_EMPTY;
        end else if (cmd == bdq_pkg::CMD_RD_INDEX &&
                     bdq_pkg::CNT_W'(index_i) >= count_q) begin
          status = bdq_pkg::ST_RANGE;
        end else begin
          rd = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign data_ext = 64'(entry_data_i);
  assign wdata_o  = data_ext[WIDTH-1:0];
  assign re_o     = acc_i & rd;
  assign raddr_o  = slot;

  assign res_o.count  = count_d;
  assign res_o.status = status;
  assign res_o.rd     = rd;

  // pointer and count update on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (acc_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bdq_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // count never exceeds the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SW'(count_q) <= SW'(DEPTH))
    else $error("entry count above depth");

  // a refused insert leaves the count alone
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && status == bdq_pkg::ST_FULL |=> $stable(count_q))
    else $error("count changed on full insert");

  // head moves only on a successful head insert or head removal
  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acc_i && status == bdq_pkg::ST_OK &&
      (cmd == bdq_pkg::CMD_INS_HEAD || cmd == bdq_pkg::CMD_REM_HEAD))
    |=> $stable(head_q))
    else $error("head pointer moved unexpectedly");

  // memory is written only by an accepted insert that was not refused
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> acc_i && status == bdq_pkg::ST_OK &&
             (cmd == bdq_pkg::CMD_INS_HEAD || cmd == bdq_pkg::CMD_INS_TAIL))
    else $error("stray memory write");

endmodule

// ----- hw/rtl/bdq_outbuf.sv -----
// ----------------------------------------------------------------------------
// bdq_outbuf
// Result staging: one stage waits for the memory read word, one output
// register faces the downstream channel.
// ----------------------------------------------------------------------------
module bdq_outbuf #(
  parameter int unsigned WIDTH = bdq_pkg::WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  bdq_pkg::res_t               res_i,
  input  logic [WIDTH-1:0]            rdata_i,
  output logic                        ready_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bdq_pkg::DATA_W-1:0]  read_data_o,
  output logic [bdq_pkg::CNT_W-1:0]   count_o,
  output logic [bdq_pkg::STAT_W-1:0]  status_o
);

  logic                        p_valid_q;
  bdq_pkg::res_t               p_q;
  logic                        out_valid_q;
  logic [bdq_pkg::DATA_W-1:0]  rdata_q;
  logic [bdq_pkg::CNT_W-1:0]   count_q;
  bdq_pkg::status_e            status_q;
  logic                        out_free;
  logic                        p_move;
  logic [63:0]                 rdata_ext;

  assign out_free = !out_valid_q || !out_stall_i;
  assign p_move   = p_valid_q && out_free;
  assign ready_o  = !p_valid_q || out_free;

  assign rdata_ext = 64'(rdata_i);

  // control: stage and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p_valid_q   <= acc_i || (p_valid_q && !p_move);
      out_valid_q <= p_move || (out_valid_q && out_stall_i);
    end
  end

  // payload: stage takes the decoded result, output takes the read word and the staged result
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      p_q <= res_i;
    end
    if (p_move) begin
      rdata_q  <= p_q.rd ? rdata_ext[bdq_pkg::DATA_W-1:0] : '0;
      count_q  <= p_q.count;
      status_q <= p_q.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;
  assign count_o     = count_q;
  assign status_o    = status_q;

  // an item is never taken while the stage is full and cannot drain
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i |-> !p_valid_q || p_move)
    else $error("result stage overrun");

  // a failed or non-read item carries a zero word
  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != bdq_pkg::ST_OK |-> rdata_q == '0)
    else $error("nonzero read word on error");

  // a waiting stage drains once the output is free
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q && out_free |=> out_valid_q)
    else $error("stage did not drain");

endmodule

// ----- hw/rtl/bounded_deque_with_indexed_read_top.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_indexed_read_top
// Bounded double-ended queue in a ring memory with an indexed read.
//
//   channel   handshake               payload
//   in        in_valid_i / in_stall_o  command_i, entry_data_i, index_i
//   out       out_valid_o / out_stall_i read_data_o, count_o, status_o
//   cfg       cfg_we_i                 cfg_wdata_i (capacity)
//
// One item per cycle sustained unless a stalled output backs up both stages.
// Each item makes at most one access to the single-port-per-side ring memory
// at its accept edge; pointer and count update at that same edge.
// Reset clears head pointer and count and sets capacity to 64; no clearing pass.
// A stalled output holds one result and one more in the read stage, then
// in_stall_o rises.
// ----------------------------------------------------------------------------
module bounded_deque_with_indexed_read_top #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = bdq_pkg::WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bdq_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bdq_pkg::CMD_W-1:0]   command_i,
  input  logic [bdq_pkg::DATA_W-1:0]  entry_data_i,
  input  logic [bdq_pkg::IDX_W-1:0]   index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bdq_pkg::DATA_W-1:0]  read_data_o,
  output logic [bdq_pkg::CNT_W-1:0]   count_o,
  output logic [bdq_pkg::STAT_W-1:0]  status_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic             ready;
  logic             acc;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [WIDTH-1:0] wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  logic [WIDTH-1:0] rdata;
  bdq_pkg::res_t    res;

  // input handshake
  assign in_stall_o = !ready;
  assign acc        = in_valid_i && ready;

  // command decode and queue state
  bdq_ctrl #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .acc_i        (acc),
    .command_i    (command_i),
    .entry_data_i (entry_data_i),
    .index_i      (index_i),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .re_o         (re),
    .raddr_o      (raddr),
    .res_o        (res)
  );

  // entry ring
  bdq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // result staging
  bdq_outbuf #(
    .WIDTH (WIDTH)
  ) u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .res_i       (res),
    .rdata_i     (rdata),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o),
    .count_o     (count_o),
    .status_o    (status_o)
  );

endmodule

// ----- dv/deque_check_pkg.sv -----
// ----------------------------------------------------------------------------
// deque_check_pkg
// Expected-result tracking for the bounded deque testbench: a mirror of the
// ring, head pointer, fill level and capacity that predicts one result per
// accepted command and checks what the block returns against it.
// ----------------------------------------------------------------------------
package deque_check_pkg;

  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  // one predicted result
  typedef struct {
    logic [DATA_W-1:0] word;
    logic [CNT_W-1:0]  cnt;
    status_e           st;
  } deque_result_t;

  class deque_scoreboard;
    logic [DATA_W-1:0] ring [DEPTH_DEF];
    logic [IDX_W-1:0]  head;
    int unsigned       held;
    logic [CNT_W-1:0]  cap_reg;
    deque_result_t     pending [$];

    // run statistics
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned commands_seen;
    int unsigned peak_held;
    int unsigned by_status [4];

    function new();
      head    = '0;
      held    = 0;
      cap_reg = CAP_RESET;
    endfunction

    function void set_capacity(logic [CNT_W-1:0] value);
      cap_reg = value;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch at result %0d: %s", results_seen, what);
    endtask

    // advance the mirror by one accepted command and queue its result
    function void note_command(cmd_e cmd, logic [DATA_W-1:0] word, logic [IDX_W-1:0] idx);
      deque_result_t r;
      int unsigned   eff_cap;
      logic [IDX_W-1:0] pos;
      eff_cap = (cap_reg > DEPTH_DEF) ? DEPTH_DEF : int'(cap_reg);
      r.word = '0;
      r.st   = ST_OK;
      case (cmd)
        CMD_INS_HEAD, CMD_INS_TAIL: begin
          if (held >= eff_cap) begin
            r.st = ST_FULL;
          end else begin
            if (cmd == CMD_INS_HEAD) begin
              head = head - 1'b1;
              pos  = head;
            end else begin
              pos = head + IDX_W'(held);
            end
            ring[pos] = word;
            held++;
          end
        end
        CMD_REM_HEAD, CMD_REM_TAIL: begin
          if (held == 0) begin
            r.st = ST_EMPTY;
          end else begin
            if (cmd == CMD_REM_HEAD) head = head + 1'b1;
            held--;
          end
        end
        CMD_RD_HEAD, CMD_RD_TAIL, CMD_RD_INDEX: begin
          if (held == 0) begin
            r.st = ST_EMPTY;
          end else if (cmd == CMD_RD_HEAD) begin
            r.word = ring[head];
          end else if (cmd == CMD_RD_TAIL) begin
            pos    = head + IDX_W'(held - 1);
            r.word = ring[pos];
          end else if (idx >= held) begin
            r.st = ST_RANGE;
          end else begin
            pos    = head + idx;
            r.word = ring[pos];
          end
        end
        default: ;
      endcase
      r.cnt = CNT_W'(held);
      if (held > peak_held) peak_held = held;
      by_status[r.st]++;
      commands_seen++;
      pending.push_back(r);
    endfunction

    // compare one accepted result with the oldest prediction
    task check_result(logic [DATA_W-1:0] word, logic [CNT_W-1:0] cnt, logic [STAT_W-1:0] st);
      deque_result_t e;
      results_seen++;
      if (pending.size() == 0) begin
        report_mismatch("result with no command waiting");
        return;
      end
      e = pending.pop_front();
      if (word !== e.word) begin
        report_mismatch($sformatf("read_data got %h want %h", word, e.word));
      end
      if (cnt !== e.cnt) begin
        report_mismatch($sformatf("count got %0d want %0d", cnt, e.cnt));
      end
      if (st !== e.st) begin
        report_mismatch($sformatf("status got %0d want %0d", st, e.st));
      end
    endtask
  endclass

endpackage

// ----- dv/bounded_deque_with_indexed_read_top_tb.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_indexed_read_top_tb
// Drives commands into the bounded deque with random idle and stall on both
// channels, mirrors the queue to predict each result and checks every field.
// A short directed run hits empty, full, wrap and range cases, then random
// phases at several capacities fill, drain and churn the queue.
// ----------------------------------------------------------------------------
module bounded_deque_with_indexed_read_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;
  import deque_check_pkg::*;

  localparam int unsigned CLK_HALF    = 2;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 38;

  typedef enum int unsigned {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_e;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CNT_W-1:0]    cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    command_i    = '0;
  logic [DATA_W-1:0]   entry_data_i = '0;
  logic [IDX_W-1:0]    index_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [DATA_W-1:0]   read_data_o;
  logic [CNT_W-1:0]    count_o;
  logic [STAT_W-1:0]   status_o;

  bit                  sender_quiet   = 1'b0;
  bit                  receiver_quiet = 1'b0;
  int unsigned         cycles         = 0;
  int unsigned         cap_writes     = 0;

  deque_scoreboard     sb = new();

  bounded_deque_with_indexed_read_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .entry_data_i (entry_data_i),
    .index_i      (index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .count_o      (count_o),
    .status_o     (status_o)
  );

  // clock
  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result check and random output stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(read_data_o, count_o, status_o);
    end
    out_stall_i <= receiver_quiet ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
  end

  // present one item, with random idle before it, and wait for acceptance
  task automatic send_item(cmd_e cmd, logic [DATA_W-1:0] word, logic [IDX_W-1:0] idx);
    if (!sender_quiet) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    entry_data_i <= word;
    index_i      <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_command(cmd, word, idx);
  endtask

  // hold off the sender until every predicted result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // capacity write while the block is idle
  task automatic write_capacity(logic [CNT_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_capacity(value);
    cap_writes++;
  endtask

  // weighted command choice for one mix
  function automatic cmd_e pick_command(mix_e mix);
    int unsigned r;
    int unsigned ins_w;
    int unsigned rem_w;
    int unsigned rd_w;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin ins_w = 70; rem_w = 10; rd_w = 15; end
      MIX_DRAIN: begin ins_w = 15; rem_w = 65; rd_w = 15; end
      default:   begin ins_w = 40; rem_w = 35; rd_w = 20; end
    endcase
    if (r < ins_w) return $urandom_range(0, 1) ? CMD_INS_HEAD : CMD_INS_TAIL;
    if (r < ins_w + rem_w) return $urandom_range(0, 1) ? CMD_REM_HEAD : CMD_REM_TAIL;
    if (r < ins_w + rem_w + rd_w) begin
      case ($urandom_range(0, 3))
        0:       return CMD_RD_HEAD;
        1:       return CMD_RD_TAIL;
        default: return CMD_RD_INDEX;
      endcase
    end
    return CMD_SIZE;
  endfunction

  // one random phase at a given capacity
  task automatic run_phase(logic [CNT_W-1:0] cap, mix_e mix, int unsigned n, bit quiet);
    cmd_e             cmd;
    logic [IDX_W-1:0] idx;
    write_capacity(cap);
    sender_quiet   = quiet;
    receiver_quiet = quiet;
    for (int unsigned i = 0; i < n; i++) begin
      cmd = pick_command(mix);
      if (sb.held > 0 && $urandom_range(0, 99) < 60) begin
        idx = IDX_W'($urandom_range(0, sb.held - 1));
      end else begin
        idx = IDX_W'($urandom_range(0, 63));
      end
      send_item(cmd, $urandom(), idx);
      // occasional full hold-off mid-phase
      if ($urandom_range(0, 99) < 2) drain_results();
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue at reset capacity
    send_item(CMD_REM_HEAD, 32'h1234_5678, 6'd0);
    send_item(CMD_REM_TAIL, 32'h0, 6'd0);
    send_item(CMD_RD_HEAD, 32'h0, 6'd0);
    send_item(CMD_RD_TAIL, 32'h0, 6'd0);
    send_item(CMD_RD_INDEX, 32'h0, 6'd0);
    send_item(CMD_SIZE, 32'hFFFF_FFFF, 6'd63);
    // data extremes, head insert wraps the ring pointer
    send_item(CMD_INS_HEAD, 32'h0000_0000, 6'd0);
    send_item(CMD_INS_TAIL, 32'hFFFF_FFFF, 6'd63);
    send_item(CMD_INS_HEAD, 32'hA5A5_A5A5, 6'd0);
    send_item(CMD_RD_HEAD, 32'h0, 6'd0);
    send_item(CMD_RD_TAIL, 32'h0, 6'd0);
    send_item(CMD_RD_INDEX, 32'h0, 6'd1);
    // index at and past the fill level
    send_item(CMD_RD_INDEX, 32'h0, 6'd3);
    send_item(CMD_RD_INDEX, 32'h0, 6'd63);
    send_item(CMD_SIZE, 32'h0, 6'd0);
    send_item(CMD_REM_TAIL, 32'h0, 6'd0);
    send_item(CMD_REM_HEAD, 32'h0, 6'd0);
    send_item(CMD_RD_INDEX, 32'h0, 6'd0);
    // capacity of one: full insert, then room after a removal
    write_capacity(7'd1);
    send_item(CMD_INS_TAIL, 32'h0F0F_0F0F, 6'd0);
    send_item(CMD_REM_HEAD, 32'h0, 6'd0);
    send_item(CMD_INS_TAIL, 32'h5A5A_5A5A, 6'd0);
    send_item(CMD_INS_HEAD, 32'hDEAD_BEEF, 6'd0);
    // capacity zero: every insert is full
    write_capacity(7'd0);
    send_item(CMD_INS_HEAD, 32'h8000_0001, 6'd0);
    send_item(CMD_REM_TAIL, 32'h0, 6'd0);
    send_item(CMD_INS_TAIL, 32'h7FFF_FFFE, 6'd0);

    // random phases; capacity above the depth saturates, and one phase has no idling
    run_phase(7'd127, MIX_FILL, 150, 1'b0);
    run_phase(7'd64, MIX_EVEN, 150, 1'b1);
    run_phase(7'd1, MIX_EVEN, 150, 1'b0);
    run_phase(7'd0, MIX_DRAIN, 150, 1'b0);
    run_phase(7'd2, MIX_EVEN, 150, 1'b0);
    run_phase(CNT_W'($urandom_range(1, 127)), MIX_FILL, 150, 1'b0);
    run_phase(7'd64, MIX_DRAIN, 150, 1'b0);
    run_phase(CNT_W'($urandom_range(3, 40)), MIX_EVEN, 150, 1'b0);
    run_phase(7'd127, MIX_FILL, 150, 1'b0);
    run_phase(7'd3, MIX_DRAIN, 150, 1'b0);

    // wind down
    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
    end

    $display("run: %0d commands, %0d results checked, %0d capacity writes, peak fill %0d",
             sb.commands_seen, sb.results_seen, cap_writes, sb.peak_held);
    $display("outcomes: %0d ok, %0d full, %0d empty, %0d out of range, %0d mismatches",
             sb.by_status[ST_OK], sb.by_status[ST_FULL], sb.by_status[ST_EMPTY],
             sb.by_status[ST_RANGE], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
